// ===== design/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants of the circle contact pipeline.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int SqrtStages = 32;
    localparam int DivStages  = 17;
    localparam int InDataW    = 288;
    localparam int OutDataW   = 136;

    localparam logic KindCircle = 1'b0;
    localparam logic KindBox    = 1'b1;

    localparam logic [16:0] OneQ = 17'h10000;

    // one input word, unpacked
    typedef struct packed {
        logic        kind;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [30:0] sr;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [30:0] orad;
        logic [30:0] hw;
        logic [30:0] hh;
        logic        plat;
        logic [30:0] plim;
    } t_item;

    // sideband that travels along the square root and divider stages
    typedef struct packed {
        logic               kind;
        logic               ok;
        logic               zero;
        logic               negx;
        logic               negy;
        logic               plat;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [31:0]        lim;
        logic [30:0]        orad;
        logic [30:0]        plim;
        logic signed [32:0] bx;
        logic signed [32:0] by;
    } t_side;

    typedef struct packed {
        logic               hit;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [30:0]        depth;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_res;

endpackage

// ===== design/circle_collider_contact.sv =====
// ----------------------------------------------------------------------------
// circle_collider_contact
// Narrow-phase contact of a circle against a circle or an axis-aligned box.
// ----------------------------------------------------------------------------
// path: front, square root, divider and back stages, then the output register to o_m_tvalid
// throughput: one word per cycle while the skid stage is free, set by the fully pipelined square root
//   (32 stages) and normal dividers (17 stages) that each item passes once
// a two-entry output (register plus skid) keeps input taken while a result waits
// reset: synchronous, active low; empties every stage, no clearing pass
// ----------------------------------------------------------------------------
module circle_collider_contact (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // self_x, self_y, self_radius, other_x, other_y, other_radius, box_half_w,
    // box_half_h, box_is_platform, platform_depth_limit, zero pad
    input  logic [ccc_pkg::InDataW-1:0]      i_s_tdata,
    // kind
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // normal_x, normal_y, depth, point_x, point_y, zero pad
    output logic [ccc_pkg::OutDataW-1:0]     o_m_tdata,
    // hit
    output logic                             o_m_tuser
);

    ccc_pkg::t_item w_item;
    logic           w_en;
    logic           w_f_v, w_s_v, w_d_v, w_b_v;
    logic [63:0]    w_sq;
    logic [31:0]    w_root, w_dist;
    logic [16:0]    w_qx, w_qy;
    ccc_pkg::t_side w_f_side, w_s_side, w_d_side;
    ccc_pkg::t_res  w_b_res;

    logic           r_ov, r_sv;
    ccc_pkg::t_res  r_od, r_sd;
    logic           w_take;

    always_comb begin
        w_item.kind = i_s_tuser;
        w_item.sx   = i_s_tdata[31:0];
        w_item.sy   = i_s_tdata[63:32];
        w_item.sr   = i_s_tdata[94:64];
        w_item.ox   = i_s_tdata[126:95];
        w_item.oy   = i_s_tdata[158:127];
        w_item.orad = i_s_tdata[189:159];
        w_item.hw   = i_s_tdata[220:190];
        w_item.hh   = i_s_tdata[251:221];
        w_item.plat = i_s_tdata[252];
        w_item.plim = i_s_tdata[283:253];
    end

    // the pipeline moves whenever the skid stage is free
    assign w_en       = !r_sv;
    assign o_s_tready = w_en;

    ccc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_item  (w_item),
        .o_valid (w_f_v),
        .o_sq    (w_sq),
        .o_side  (w_f_side)
    );

    ccc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_rad   (w_sq),
        .i_side  (w_f_side),
        .o_valid (w_s_v),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    ccc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_v),
        .i_dist  (w_root),
        .i_side  (w_s_side),
        .o_valid (w_d_v),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_dist  (w_dist),
        .o_side  (w_d_side)
    );

    ccc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_qx    (w_qx),
        .i_qy    (w_qy),
        .i_dist  (w_dist),
        .i_side  (w_d_side),
        .o_valid (w_b_v),
        .o_res   (w_b_res)
    );

    assign w_take = r_ov && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (w_b_v) begin
            if (r_ov && !w_take) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!r_ov || w_take) begin
                r_od <= r_sd;
            end
        end else if (w_b_v) begin
            if (r_ov && !w_take) begin
                r_sd <= w_b_res;
            end else begin
                r_od <= w_b_res;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_od.hit;
    assign o_m_tdata  = {5'd0, r_od.py, r_od.px, r_od.depth, r_od.ny, r_od.nx};

    a_skid_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid word held with output register empty");

    a_miss_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("missed contact carries nonzero payload");

    a_normal_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_od.nx <= 18'sd65536 && r_od.nx >= -18'sd65536
                        && r_od.ny <= 18'sd65536 && r_od.ny >= -18'sd65536))
        else $error("normal component outside unit range");

    a_reset_empty : assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_m_tvalid && o_s_tready))
        else $error("output not empty after reset");

endmodule

// ===== design/ccc_front.sv =====
// ----------------------------------------------------------------------------
// ccc_front
// Offsets, box clamp, range check and exact squared distance (five stages).
// ----------------------------------------------------------------------------
module ccc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ccc_pkg::t_item      i_item,
    output logic                o_valid,
    output logic [63:0]         o_sq,
    output ccc_pkg::t_side      o_side
);

    // stage 1
    logic               r1_v, r1_kind, r1_plat;
    logic signed [31:0] r1_sx, r1_sy, r1_ox, r1_oy;
    logic [31:0]        r1_lim;
    logic [30:0]        r1_orad, r1_plim;
    logic signed [32:0] r1_cdx, r1_cdy, r1_lox, r1_hix, r1_loy, r1_hiy;
    logic signed [32:0] n1_sx, n1_sy, n1_ox, n1_oy;

    // stage 2
    logic               r2_v, r2_kind, r2_plat;
    logic [31:0]        r2_lim;
    logic [30:0]        r2_orad, r2_plim;
    logic signed [33:0] r2_dx, r2_dy;
    logic signed [32:0] r2_bx, r2_by;
    logic signed [32:0] n2_sx, n2_sy, n2_cx, n2_cy;
    logic signed [33:0] n2_dx, n2_dy;

    // stage 3
    logic               r3_v;
    ccc_pkg::t_side     r3_side;
    logic [33:0]        n3_ax, n3_ay;
    ccc_pkg::t_side     n3_side;

    // stage 4
    logic               r4_v;
    ccc_pkg::t_side     r4_side;
    logic [63:0]        r4_sqx, r4_sqy, r4_sql;

    // stage 5
    logic               r5_v;
    ccc_pkg::t_side     r5_side;
    logic [63:0]        r5_sq;
    logic [64:0]        n5_sum;
    ccc_pkg::t_side     n5_side;

    always_comb begin
        n1_sx = {i_item.sx[31], i_item.sx};
        n1_sy = {i_item.sy[31], i_item.sy};
        n1_ox = {i_item.ox[31], i_item.ox};
        n1_oy = {i_item.oy[31], i_item.oy};
    end

    always_comb begin
        n2_sx = {r1_sx[31], r1_sx};
        n2_sy = {r1_sy[31], r1_sy};
        if (n2_sx < r1_lox)      n2_cx = r1_lox;
        else if (n2_sx > r1_hix) n2_cx = r1_hix;
        else                     n2_cx = n2_sx;
        if (n2_sy < r1_loy)      n2_cy = r1_loy;
        else if (n2_sy > r1_hiy) n2_cy = r1_hiy;
        else                     n2_cy = n2_sy;
        if (r1_kind == ccc_pkg::KindBox) begin
            n2_dx = {n2_sx[32], n2_sx} - {n2_cx[32], n2_cx};
            n2_dy = {n2_sy[32], n2_sy} - {n2_cy[32], n2_cy};
        end else begin
            n2_dx = {r1_cdx[32], r1_cdx};
            n2_dy = {r1_cdy[32], r1_cdy};
        end
    end

    always_comb begin
        n3_ax = r2_dx[33] ? 34'(-r2_dx) : 34'(r2_dx);
        n3_ay = r2_dy[33] ? 34'(-r2_dy) : 34'(r2_dy);
        n3_side.kind = r2_kind;
        n3_side.ok   = (n3_ax <= {2'b0, r2_lim}) && (n3_ay <= {2'b0, r2_lim});
        n3_side.zero = 1'b0;
        n3_side.negx = r2_dx[33];
        n3_side.negy = r2_dy[33];
        n3_side.plat = r2_plat;
        n3_side.ax   = n3_ax[31:0];
        n3_side.ay   = n3_ay[31:0];
        n3_side.lim  = r2_lim;
        n3_side.orad = r2_orad;
        n3_side.plim = r2_plim;
        n3_side.bx   = r2_bx;
        n3_side.by   = r2_by;
    end

    assign n5_sum = {1'b0, r4_sqx} + {1'b0, r4_sqy};

    always_comb begin
        n5_side      = r4_side;
        n5_side.ok   = r4_side.ok && (n5_sum <= {1'b0, r4_sql});
        n5_side.zero = (n5_sum == 65'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_item.kind;
            r1_plat <= i_item.plat;
            r1_sx   <= i_item.sx;
            r1_sy   <= i_item.sy;
            r1_ox   <= i_item.ox;
            r1_oy   <= i_item.oy;
            r1_orad <= i_item.orad;
            r1_plim <= i_item.plim;
            r1_lim  <= (i_item.kind == ccc_pkg::KindBox) ? {1'b0, i_item.sr}
                       : ({1'b0, i_item.sr} + {1'b0, i_item.orad});
            r1_cdx  <= n1_sx - n1_ox;
            r1_cdy  <= n1_sy - n1_oy;
            r1_lox  <= n1_ox - $signed({2'b0, i_item.hw});
            r1_hix  <= n1_ox + $signed({2'b0, i_item.hw});
            r1_loy  <= n1_oy - $signed({2'b0, i_item.hh});
            r1_hiy  <= n1_oy + $signed({2'b0, i_item.hh});

            r2_kind <= r1_kind;
            r2_plat <= r1_plat;
            r2_lim  <= r1_lim;
            r2_orad <= r1_orad;
            r2_plim <= r1_plim;
            r2_dx   <= n2_dx;
            r2_dy   <= n2_dy;
            r2_bx   <= (r1_kind == ccc_pkg::KindBox) ? n2_cx : {r1_ox[31], r1_ox};
            r2_by   <= (r1_kind == ccc_pkg::KindBox) ? n2_cy : {r1_oy[31], r1_oy};

            r3_side <= n3_side;

            r4_side <= r3_side;
            r4_sqx  <= r3_side.ax * r3_side.ax;
            r4_sqy  <= r3_side.ay * r3_side.ay;
            r4_sql  <= r3_side.lim * r3_side.lim;

            r5_side <= n5_side;
            r5_sq   <= n5_sum[63:0];
        end
    end

    assign o_valid = r5_v;
    assign o_sq    = r5_sq;
    assign o_side  = r5_side;

endmodule

// ===== design/ccc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccc_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ccc_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_rad,
    input  ccc_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [31:0]         o_root,
    output ccc_pkg::t_side      o_side
);

    logic [ccc_pkg::SqrtStages-1:0] r_v;
    logic [64:0]    r_rem  [ccc_pkg::SqrtStages];
    logic [31:0]    r_root [ccc_pkg::SqrtStages];
    ccc_pkg::t_side r_side [ccc_pkg::SqrtStages];
    logic [64:0]    n_rem  [ccc_pkg::SqrtStages];
    logic [31:0]    n_root [ccc_pkg::SqrtStages];

    // stage j settles root bit 31-j against the running remainder
    always_comb begin
        logic [64:0] s_rem;
        logic [64:0] s_trial;
        logic [31:0] s_root;
        for (int j = 0; j < ccc_pkg::SqrtStages; j++) begin
            s_rem   = (j == 0) ? {1'b0, i_rad} : r_rem[j-1];
            s_root  = (j == 0) ? 32'd0 : r_root[j-1];
            s_trial = ({33'd0, s_root} << (ccc_pkg::SqrtStages - j))
                    + (65'd1 << (2 * (ccc_pkg::SqrtStages - 1 - j)));
            if (s_rem >= s_trial) begin
                n_rem[j]  = s_rem - s_trial;
                n_root[j] = s_root | (32'd1 << (ccc_pkg::SqrtStages - 1 - j));
            end else begin
                n_rem[j]  = s_rem;
                n_root[j] = s_root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ccc_pkg::SqrtStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < ccc_pkg::SqrtStages; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[ccc_pkg::SqrtStages-1];
    assign o_root  = r_root[ccc_pkg::SqrtStages-1];
    assign o_side  = r_side[ccc_pkg::SqrtStages-1];

endmodule

// ===== design/ccc_div.sv =====
// ----------------------------------------------------------------------------
// ccc_div
// Normal components: two lockstep restoring dividers, one quotient bit per
// stage, after one stage that forms the rounded numerators.
// ----------------------------------------------------------------------------
module ccc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_dist,
    input  ccc_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [16:0]         o_qx,
    output logic [16:0]         o_qy,
    output logic [31:0]         o_dist,
    output ccc_pkg::t_side      o_side
);

    logic           r_p_v;
    logic [48:0]    r_p_nx, r_p_ny;
    logic [31:0]    r_p_dist;
    ccc_pkg::t_side r_p_side;

    logic [ccc_pkg::DivStages-1:0] r_v;
    logic [48:0]    r_rx   [ccc_pkg::DivStages];
    logic [48:0]    r_ry   [ccc_pkg::DivStages];
    logic [16:0]    r_qx   [ccc_pkg::DivStages];
    logic [16:0]    r_qy   [ccc_pkg::DivStages];
    logic [31:0]    r_dist [ccc_pkg::DivStages];
    ccc_pkg::t_side r_side [ccc_pkg::DivStages];
    logic [48:0]    n_rx   [ccc_pkg::DivStages];
    logic [48:0]    n_ry   [ccc_pkg::DivStages];
    logic [16:0]    n_qx   [ccc_pkg::DivStages];
    logic [16:0]    n_qy   [ccc_pkg::DivStages];

    always_comb begin
        logic [48:0] s_rx, s_ry, s_dsh;
        logic [16:0] s_qx, s_qy;
        logic [31:0] s_d;
        for (int j = 0; j < ccc_pkg::DivStages; j++) begin
            s_rx  = (j == 0) ? r_p_nx : r_rx[j-1];
            s_ry  = (j == 0) ? r_p_ny : r_ry[j-1];
            s_qx  = (j == 0) ? 17'd0 : r_qx[j-1];
            s_qy  = (j == 0) ? 17'd0 : r_qy[j-1];
            s_d   = (j == 0) ? r_p_dist : r_dist[j-1];
            s_dsh = {17'd0, s_d} << (ccc_pkg::DivStages - 1 - j);
            n_rx[j] = s_rx;
            n_qx[j] = s_qx;
            n_ry[j] = s_ry;
            n_qy[j] = s_qy;
            if (s_rx >= s_dsh) begin
                n_rx[j] = s_rx - s_dsh;
                n_qx[j] = s_qx | (17'd1 << (ccc_pkg::DivStages - 1 - j));
            end
            if (s_ry >= s_dsh) begin
                n_ry[j] = s_ry - s_dsh;
                n_qy[j] = s_qy | (17'd1 << (ccc_pkg::DivStages - 1 - j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_v   <= '0;
        end else if (i_en) begin
            r_p_v <= i_valid;
            r_v   <= {r_v[ccc_pkg::DivStages-2:0], r_p_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offset scaled to Q16 plus half the divisor for round half up
            r_p_nx   <= {1'b0, i_side.ax, 16'd0} + {18'd0, i_dist[31:1]};
            r_p_ny   <= {1'b0, i_side.ay, 16'd0} + {18'd0, i_dist[31:1]};
            r_p_dist <= i_dist;
            r_p_side <= i_side;
            for (int j = 0; j < ccc_pkg::DivStages; j++) begin
                r_rx[j]   <= n_rx[j];
                r_ry[j]   <= n_ry[j];
                r_qx[j]   <= n_qx[j];
                r_qy[j]   <= n_qy[j];
                r_dist[j] <= (j == 0) ? r_p_dist : r_dist[j-1];
                r_side[j] <= (j == 0) ? r_p_side : r_side[j-1];
            end
        end
    end

    assign o_valid = r_v[ccc_pkg::DivStages-1];
    assign o_qx    = r_qx[ccc_pkg::DivStages-1];
    assign o_qy    = r_qy[ccc_pkg::DivStages-1];
    assign o_dist  = r_dist[ccc_pkg::DivStages-1];
    assign o_side  = r_side[ccc_pkg::DivStages-1];

endmodule

// ===== design/ccc_back.sv =====
// ----------------------------------------------------------------------------
// ccc_back
// Signed normals, depth, platform rejection, rim offset and saturated point.
// ----------------------------------------------------------------------------
module ccc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [16:0]         i_qx,
    input  logic [16:0]         i_qy,
    input  logic [31:0]         i_dist,
    input  ccc_pkg::t_side      i_side,
    output logic                o_valid,
    output ccc_pkg::t_res       o_res
);

    localparam logic signed [34:0] MaxQ = 35'sd2147483647;
    localparam logic signed [34:0] MinQ = -35'sd2147483648;

    logic [16:0]        n1_mx, n1_my;
    logic [31:0]        n1_depth;
    logic               n1_rej;

    logic               r1_v, r1_hit, r1_negx, r1_negy;
    logic signed [17:0] r1_nx, r1_ny;
    logic [30:0]        r1_depth;
    logic [47:0]        r1_prx, r1_pry;
    logic signed [32:0] r1_bx, r1_by;

    logic               r2_v;
    ccc_pkg::t_res      r2_res;

    logic [48:0]        n2_rx, n2_ry;
    logic signed [34:0] n2_ox, n2_oy, n2_sx, n2_sy;
    logic signed [31:0] n2_px, n2_py;

    always_comb begin
        if (i_side.zero) begin
            n1_mx = (i_side.kind == ccc_pkg::KindBox) ? 17'd0 : ccc_pkg::OneQ;
            n1_my = (i_side.kind == ccc_pkg::KindBox) ? ccc_pkg::OneQ : 17'd0;
        end else begin
            n1_mx = i_qx;
            n1_my = i_qy;
        end
        n1_depth = i_side.lim - i_dist;
        // platform: pushed downward out of the box, or too deep
        n1_rej = (i_side.kind == ccc_pkg::KindBox) && i_side.plat
               && ((i_side.negy && (n1_my != 17'd0))
                   || (n1_depth > {1'b0, i_side.plim}));
    end

    always_comb begin
        n2_rx = {1'b0, r1_prx} + 49'h8000;
        n2_ry = {1'b0, r1_pry} + 49'h8000;
        n2_ox = r1_negx ? -$signed({2'b0, n2_rx[48:16]}) : $signed({2'b0, n2_rx[48:16]});
        n2_oy = r1_negy ? -$signed({2'b0, n2_ry[48:16]}) : $signed({2'b0, n2_ry[48:16]});
        n2_sx = $signed({r1_bx[32], r1_bx[32], r1_bx}) + n2_ox;
        n2_sy = $signed({r1_by[32], r1_by[32], r1_by}) + n2_oy;
        if (n2_sx > MaxQ)      n2_px = MaxQ[31:0];
        else if (n2_sx < MinQ) n2_px = MinQ[31:0];
        else                   n2_px = n2_sx[31:0];
        if (n2_sy > MaxQ)      n2_py = MaxQ[31:0];
        else if (n2_sy < MinQ) n2_py = MinQ[31:0];
        else                   n2_py = n2_sy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hit   <= i_side.ok && !n1_rej;
            r1_negx  <= i_side.negx;
            r1_negy  <= i_side.negy;
            r1_nx    <= i_side.negx ? -$signed({1'b0, n1_mx}) : $signed({1'b0, n1_mx});
            r1_ny    <= i_side.negy ? -$signed({1'b0, n1_my}) : $signed({1'b0, n1_my});
            r1_depth <= n1_depth[31] ? 31'h7FFFFFFF : n1_depth[30:0];
            // rim offset only for a circle, a box point is the clamp itself
            r1_prx   <= (i_side.kind == ccc_pkg::KindBox) ? 48'd0 : n1_mx * i_side.orad;
            r1_pry   <= (i_side.kind == ccc_pkg::KindBox) ? 48'd0 : n1_my * i_side.orad;
            r1_bx    <= i_side.bx;
            r1_by    <= i_side.by;

            r2_res.hit   <= r1_hit;
            r2_res.nx    <= r1_hit ? r1_nx : 18'sd0;
            r2_res.ny    <= r1_hit ? r1_ny : 18'sd0;
            r2_res.depth <= r1_hit ? r1_depth : 31'd0;
            r2_res.px    <= r1_hit ? n2_px : 32'sd0;
            r2_res.py    <= r1_hit ? n2_py : 32'sd0;
        end
    end

    assign o_valid = r2_v;
    assign o_res   = r2_res;

endmodule
